>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the frame receiver parser
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, suppressed while reset is high
`define WSFR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wsfr assertion failed");

// clocked check, active during reset too
`define WSFR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wsfr assertion failed");

`endif

>>> hw/rtl/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// Types and constants of the websocket frame receiver
// ----------------------------------------------------------------------------
package wsfr_pkg;

  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_EXTLEN  = 2'd1,
    PH_MASK    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_len;
    logic [7:0]  data;
    logic        last;
  } res_t;

endpackage

>>> hw/rtl/wsfr_in_stage.sv
// ----------------------------------------------------------------------------
// wsfr_in_stage
// Input register for the received byte stream
// ----------------------------------------------------------------------------
module wsfr_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] data_byte,
  output logic       byte_stall,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic take;

  // the held item leaves whenever the parser can advance
  assign byte_stall = held_valid && !advance;
  assign take       = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_byte <= data_byte;
    end
  end

endmodule

>>> hw/rtl/wsfr_parser.sv
// ----------------------------------------------------------------------------
// wsfr_parser
// Frame header parser, payload unmasking and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                held_valid,
  input  logic [7:0]          held_byte,
  output logic                advance,
  output logic                result_valid,
  input  logic                result_stall,
  output wsfr_pkg::res_t      result
);
  import wsfr_pkg::*;

  phase_t      phase, phase_next;
  logic [63:0] bytes_left, bytes_left_next;
  logic [8:0]  header_bits, header_bits_next;
  logic [63:0] frame_length, frame_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_index, key_index_next;

  logic        step;
  logic        final_byte;
  logic        len_done;
  logic        hdr_emit;
  logic        emit;
  logic        last_bit;
  logic        kind_bit;
  logic [7:0]  data_bits;
  logic [7:0]  key_byte;
  logic [63:0] bytes_dec;
  res_t        res_next;

  assign advance    = !result_valid || !result_stall;
  assign step       = held_valid && advance;
  assign final_byte = (bytes_left <= 64'd1);
  assign bytes_dec  = bytes_left - 64'd1;

  always_comb begin
    unique case (key_index)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      bytes_left   <= 64'd2;
      header_bits  <= '0;
      frame_length <= '0;
      mask_key     <= '0;
      key_index    <= '0;
    end else if (step) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      header_bits  <= header_bits_next;
      frame_length <= frame_length_next;
      mask_key     <= mask_key_next;
      key_index    <= key_index_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    header_bits_next  = header_bits;
    frame_length_next = frame_length;
    mask_key_next     = mask_key;
    key_index_next    = key_index;
    len_done          = 1'b0;
    hdr_emit          = 1'b0;
    emit              = 1'b0;
    last_bit          = 1'b0;
    kind_bit          = KIND_HEADER;
    data_bits         = '0;

    unique case (phase)
      PH_HEADER: begin
        if (!final_byte) begin
          header_bits_next = {held_byte[7], held_byte[6:4], held_byte[3:0], 1'b0};
          bytes_left_next  = 64'd1;
        end else begin
          header_bits_next  = {header_bits[8:1], held_byte[7]};
          mask_key_next     = '0;
          frame_length_next = '0;
          if (held_byte[6:0] == LEN_CODE16) begin
            phase_next      = PH_EXTLEN;
            bytes_left_next = 64'd2;
          end else if (held_byte[6:0] == LEN_CODE64) begin
            phase_next      = PH_EXTLEN;
            bytes_left_next = 64'd8;
          end else begin
            frame_length_next = {57'd0, held_byte[6:0]};
            len_done          = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        frame_length_next = {frame_length[55:0], held_byte};
        if (!final_byte) begin
          bytes_left_next = bytes_dec;
        end else begin
          len_done = 1'b1;
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], held_byte};
        if (!final_byte) begin
          bytes_left_next = bytes_dec;
        end else begin
          hdr_emit = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        emit           = 1'b1;
        kind_bit       = KIND_PAYLOAD;
        data_bits      = held_byte ^ key_byte;
        key_index_next = key_index + 2'd1;
        if (final_byte) begin
          last_bit        = 1'b1;
          phase_next      = PH_HEADER;
          bytes_left_next = 64'd2;
        end else begin
          bytes_left_next = bytes_dec;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase

    // length known: either the key follows or the header is complete
    if (len_done) begin
      if (header_bits_next[0]) begin
        phase_next      = PH_MASK;
        bytes_left_next = 64'd4;
        mask_key_next   = '0;
      end else begin
        hdr_emit = 1'b1;
      end
    end

    if (hdr_emit) begin
      emit           = 1'b1;
      key_index_next = '0;
      if (frame_length_next == 64'd0) begin
        last_bit        = 1'b1;
        phase_next      = PH_HEADER;
        bytes_left_next = 64'd2;
      end else begin
        phase_next      = PH_PAYLOAD;
        bytes_left_next = frame_length_next;
      end
    end

    res_next.kind        = kind_bit;
    res_next.fin         = header_bits_next[8];
    res_next.rsv         = header_bits_next[7:5];
    res_next.opcode      = header_bits_next[4:1];
    res_next.masked      = header_bits_next[0];
    res_next.payload_len = frame_length_next;
    res_next.data        = data_bits;
    res_next.last        = last_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result <= res_next;
    end
  end

  `WSFR_ASSERT(a_header_count, clk, rst,
    (phase == PH_HEADER) |-> (bytes_left == 64'd1 || bytes_left == 64'd2))
  `WSFR_ASSERT(a_payload_emits, clk, rst,
    (step && phase == PH_PAYLOAD) |=> (result_valid && result.kind == KIND_PAYLOAD))
  `WSFR_ASSERT(a_mask_needs_flag, clk, rst,
    (phase == PH_MASK) |-> header_bits[0])
  `WSFR_ASSERT(a_empty_header_last, clk, rst,
    (result_valid && result.kind == KIND_HEADER && result.last) |-> (result.payload_len == 64'd0))
  `WSFR_ASSERT(a_no_step_on_stall, clk, rst,
    (result_valid && result_stall) |-> !step)

endmodule

>>> hw/rtl/websocket_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver_unit
// WebSocket frame receiver: parses headers and unmasks payload bytes
// ----------------------------------------------------------------------------
//  channel   valid         stall         payload
//  bytes in  byte_valid    byte_stall    data_byte
//  results   result_valid  result_stall  kind fin rsv opcode masked
//                                        payload_len data last
//
//  one item per cycle sustained while results are not stalled; a result item
//  passes through the input register, then the result register
//  only the last header byte of a frame and each payload byte give a result
//  rst is synchronous and returns the parser to the start of a frame header
//  a stalled result holds the byte in the input register; one more item is
//  still accepted behind a waiting result
// ----------------------------------------------------------------------------
module websocket_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic        fin,
  output logic [2:0]  rsv,
  output logic [3:0]  opcode,
  output logic        masked,
  output logic [63:0] payload_len,
  output logic [7:0]  data,
  output logic        last
);
  import wsfr_pkg::*;

  logic       advance;
  logic       held_valid;
  logic [7:0] held_byte;
  res_t       result;

  wsfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .data_byte  (data_byte),
    .byte_stall (byte_stall),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsfr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .held_valid   (held_valid),
    .held_byte    (held_byte),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign kind        = result.kind;
  assign fin         = result.fin;
  assign rsv         = result.rsv;
  assign opcode      = result.opcode;
  assign masked      = result.masked;
  assign payload_len = result.payload_len;
  assign data        = result.data;
  assign last        = result.last;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the websocket frame receiver: drives byte streams of
// frames with random headers, lengths, keys and payloads, tracks
// the parser state alongside the block and compares every result field.
// ----------------------------------------------------------------------------
module tb;
  import wsfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int          HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        kind;
  logic        fin;
  logic [2:0]  rsv;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] payload_len;
  logic [7:0]  data;
  logic        last;

  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_cnt = 0;
  int          mismatches = 0;
  int unsigned cycle_cnt = 0;

  // parser state tracked by the bench
  phase_t      parse_ph = PH_HEADER;
  logic [63:0] left_cnt = 64'd2;
  logic [6:0]  len_code = 7'd0;
  logic [8:0]  hdr = 9'd0;
  logic [63:0] frame_len = 64'd0;
  logic [31:0] key = 32'd0;
  logic [1:0]  key_pos = 2'd0;
  res_t        parsed_q[$];
  res_t        want;

  websocket_frame_receiver_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .fin          (fin),
    .rsv          (rsv),
    .opcode       (opcode),
    .masked       (masked),
    .payload_len  (payload_len),
    .data         (data),
    .last         (last)
  );

  always #5 clk = ~clk;

  function automatic void push_parsed(logic k, logic [7:0] d, logic lst);
    res_t r;
    r.kind        = k;
    r.fin         = hdr[8];
    r.rsv         = hdr[7:5];
    r.opcode      = hdr[4:1];
    r.masked      = hdr[0];
    r.payload_len = frame_len;
    r.data        = d;
    r.last        = lst;
    parsed_q.push_back(r);
  endfunction

  function automatic void header_done();
    push_parsed(KIND_HEADER, 8'h00, frame_len == 64'd0);
    key_pos = 2'd0;
    if (frame_len == 64'd0) begin
      parse_ph = PH_HEADER;
      left_cnt = 64'd2;
    end else begin
      parse_ph = PH_PAYLOAD;
      left_cnt = frame_len;
    end
  endfunction

  function automatic void length_complete();
    if (hdr[0]) begin
      parse_ph = PH_MASK;
      left_cnt = 64'd4;
      key      = 32'd0;
    end else begin
      header_done();
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic       at_end;
    logic [7:0] kb;
    at_end = (left_cnt <= 64'd1);
    case (parse_ph)
      PH_HEADER: begin
        if (!at_end) begin
          hdr      = {b[7], b[6:4], b[3:0], 1'b0};
          left_cnt = 64'd1;
        end else begin
          hdr[0]    = b[7];
          len_code  = b[6:0];
          key       = 32'd0;
          frame_len = 64'd0;
          if (len_code == LEN_CODE16) begin
            parse_ph = PH_EXTLEN;
            left_cnt = 64'd2;
          end else if (len_code == LEN_CODE64) begin
            parse_ph = PH_EXTLEN;
            left_cnt = 64'd8;
          end else begin
            frame_len = {57'd0, len_code};
            length_complete();
          end
        end
      end
      PH_EXTLEN: begin
        frame_len = {frame_len[55:0], b};
        if (!at_end) left_cnt = left_cnt - 64'd1;
        else length_complete();
      end
      PH_MASK: begin
        key = {key[23:0], b};
        if (!at_end) left_cnt = left_cnt - 64'd1;
        else header_done();
      end
      default: begin
        kb = key[8*(3-key_pos) +: 8];
        push_parsed(KIND_PAYLOAD, b ^ kb, at_end);
        key_pos = key_pos + 2'd1;
        if (at_end) begin
          parse_ph = PH_HEADER;
          left_cnt = 64'd2;
        end else begin
          left_cnt = left_cnt - 64'd1;
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (parsed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d data %0h",
                 $time, kind, data);
        mismatches++;
      end else begin
        want = parsed_q.pop_front();
        check_field("kind", 64'(want.kind), 64'(kind));
        check_field("fin", 64'(want.fin), 64'(fin));
        check_field("rsv", 64'(want.rsv), 64'(rsv));
        check_field("opcode", 64'(want.opcode), 64'(opcode));
        check_field("masked", 64'(want.masked), 64'(masked));
        check_field("payload_len", want.payload_len, payload_len);
        check_field("data", 64'(want.data), 64'(data));
        check_field("last", 64'(want.last), 64'(last));
      end
    end
  end

  // receiver side: random stall, or a long hold when requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_cnt     <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    parse_byte(b);
  endtask

  task automatic send_frame(input logic fin_b, input logic [2:0] rsv_b,
                            input logic [3:0] op_b, input logic msk,
                            input logic [6:0] code, input logic [63:0] len,
                            input logic [31:0] mkey, input int npay);
    send_byte({fin_b, rsv_b, op_b});
    send_byte({msk, code});
    if (code == LEN_CODE16) begin
      for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    end else if (code == LEN_CODE64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
    if (msk) begin
      for (int i = 3; i >= 0; i--) send_byte(mkey[8*i +: 8]);
    end
    for (int i = 0; i < npay; i++) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_random_frame();
    int          pick;
    logic [6:0]  code;
    logic [63:0] len;
    pick = $urandom_range(99);
    if (pick < 8) begin
      len  = 64'd0;
      code = 7'd0;
    end else if (pick < 78) begin
      len  = 64'($urandom_range(12, 1));
      code = len[6:0];
    end else if (pick < 88) begin
      // extended lengths, always below the minimal encoding
      len  = 64'($urandom_range(20));
      code = LEN_CODE16;
    end else if (pick < 96) begin
      len  = 64'($urandom_range(20));
      code = LEN_CODE64;
    end else begin
      len  = 64'($urandom_range(125, 100));
      code = len[6:0];
    end
    send_frame(1'($urandom_range(1)), 3'($urandom_range(7)), 4'($urandom_range(15)),
               1'($urandom_range(1)), code, len, $urandom(), int'(len));
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // empty ping: header item carries last
    send_frame(1'b1, 3'b000, 4'h9, 1'b0, 7'd0, 64'd0, 32'd0, 0);
    // masked, key index wraps past four bytes, all reserved bits set
    send_frame(1'b0, 3'b111, 4'hF, 1'b1, 7'd5, 64'd5, 32'hA5C3_0F7E, 5);
    // 16-bit length far below its minimal encoding
    send_frame(1'b1, 3'b101, 4'h2, 1'b0, LEN_CODE16, 64'd1, 32'd0, 1);
    // empty frame through a 64-bit length
    send_frame(1'b0, 3'b010, 4'h0, 1'b0, LEN_CODE64, 64'd0, 32'd0, 0);
    // empty masked frame: header item after the key
    send_frame(1'b1, 3'b001, 4'h8, 1'b1, 7'd0, 64'd0, 32'hFFFF_FFFF, 0);
  endtask

  task automatic test_random(input int idle_p, input int stall_p, input int frames);
    idle_pct  = idle_p;
    stall_pct = stall_p;
    for (int i = 0; i < frames; i++) send_random_frame();
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = ~hold_req;
    // longest direct length while results are held back
    send_frame(1'b1, 3'b000, 4'h1, 1'b1, 7'd125, 64'd125, $urandom(), 125);
  endtask

  task automatic test_open_frame();
    idle_pct  = 10;
    stall_pct = 10;
    // full 64-bit length with the top bit set; the frame never completes
    send_frame(1'b1, 3'b110, 4'h2, 1'b1, LEN_CODE64, 64'hFFFF_FFFF_FFFF_FFFF,
               $urandom(), 24);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 18);
    test_random(73, 0, 18);
    test_random(0, 73, 18);
    test_random(10, 10, 18);
    test_backpressure();
    test_random(0, 0, 4);
    test_open_frame();
    byte_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
